FILE: rtl/core/ibc_pkg.sv
// Shared widths, codes and control structures of the IMU bias calibration unit.
`timescale 1ns / 1ps

package ibc_pkg;

   localparam int AXIS_W    = 16;
   localparam int SUM_W     = 25;
   localparam int VAL_W     = 18;
   localparam int CNT_W     = 8;
   localparam int NUM_LANES = 3;
   localparam int FRAME_W   = 2 * NUM_LANES * AXIS_W;

   localparam logic [AXIS_W-1:0] GRAVITY_RESET = 16'd8196;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_GYRO_INIT = 2'd1,
      PH_GYRO      = 2'd2,
      PH_ACCEL     = 2'd3
   } ibc_phase_type;

   typedef enum logic [1:0] {
      DIV_IDLE  = 2'd0,
      DIV_ABS   = 2'd1,
      DIV_MUL   = 2'd2,
      DIV_WRITE = 2'd3
   } ibc_div_state_type;

   typedef struct packed {
      logic load_init;
      logic accumulate;
      logic capture;
   } ibc_lane_ctrl_type;

   typedef struct packed {
      logic clr_gyro;
      logic clr_accel;
      logic wr_gyro;
      logic wr_accel;
   } ibc_offset_ctrl_type;

   typedef struct packed {
      logic use_gyro;
      logic accel_zero;
      logic gyro_done;
      logic accel_done;
      logic busy;
   } ibc_cal_status_type;

endpackage

FILE: rtl/core/ibc_axis_lane.sv
// One axis lane: running calibration sum and constant-divisor offset pipeline.
`timescale 1ns / 1ps

module ibc_axis_lane #(
   parameter int SAMPLES = 200
) (
   input  logic                               clock,
   input  ibc_pkg::ibc_lane_ctrl_type         lane_ctrl,
   input  logic signed [ibc_pkg::VAL_W-1:0]   add_val,
   input  logic signed [ibc_pkg::VAL_W-1:0]   init_val,
   output logic        [ibc_pkg::AXIS_W-1:0]  quotient
);

   localparam int SUM_W   = ibc_pkg::SUM_W;
   localparam int VAL_W   = ibc_pkg::VAL_W;
   localparam int AXIS_W  = ibc_pkg::AXIS_W;
   localparam int LOG_D   = $clog2(SAMPLES);
   localparam int SHIFT   = SUM_W + LOG_D;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  src_ff, src_in;
   logic [SUM_W-1:0]  abs_ff, abs_in;
   logic              neg_abs_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg_prod_ff;
   logic [SUM_W-1:0]  add_ext, init_ext, sum_next;
   logic [PROD_W-1:0] prod_shift;
   logic [AXIS_W-1:0] quot_mag;

   always_comb begin
      add_ext  = {{(SUM_W-VAL_W){add_val[VAL_W-1]}}, add_val};
      init_ext = {{(SUM_W-VAL_W){init_val[VAL_W-1]}}, init_val};
      sum_next = sum_ff + add_ext;
      priority if (lane_ctrl.load_init) begin
         sum_in = init_ext;
      end else if (lane_ctrl.accumulate) begin
         sum_in = sum_next;
      end else begin
         sum_in = sum_ff;
      end
      src_in     = lane_ctrl.capture ? sum_next : src_ff;
      abs_in     = src_ff[SUM_W-1] ? (~src_ff + 1'b1) : src_ff;
      prod_in    = PROD_W'(abs_ff) * PROD_W'(RECIP);
      prod_shift = prod_ff >> SHIFT;
      quot_mag   = prod_shift[AXIS_W-1:0];
      quotient   = neg_prod_ff ? (~quot_mag + 1'b1) : quot_mag;
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      src_ff      <= src_in;
      abs_ff      <= abs_in;
      neg_abs_ff  <= src_ff[SUM_W-1];
      prod_ff     <= prod_in;
      neg_prod_ff <= neg_abs_ff;
   end

endmodule

FILE: rtl/core/ibc_cal_ctrl.sv
// Calibration sequencer: phases, request queue, sample count and offset division timing.
`timescale 1ns / 1ps

module ibc_cal_ctrl #(
   parameter int SAMPLES = 200
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          gyro_req,
   input  logic                          accel_req,
   output ibc_pkg::ibc_lane_ctrl_type    lane_ctrl,
   output ibc_pkg::ibc_offset_ctrl_type  offset_ctrl,
   output ibc_pkg::ibc_cal_status_type   status
);

   localparam int CNT_W = ibc_pkg::CNT_W;
   localparam logic [CNT_W-1:0] SAMPLES_CNT = CNT_W'(SAMPLES);

   ibc_pkg::ibc_phase_type     phase_ff, phase_in, phase;
   ibc_pkg::ibc_div_state_type div_ff, div_in;
   logic [CNT_W-1:0] count_ff, count_in, cnt;
   logic [1:0]       pending_ff, pending_in, pend;
   logic             div_gyro_ff, div_gyro_in;
   logic             gyro_act, gyro_zero, gyro_fin;
   logic             accel_act, accel_zero, accel_fin;

   always_comb begin
      pend       = pending_ff | {accel_req, gyro_req};
      phase      = phase_ff;
      cnt        = count_ff;
      gyro_act   = 1'b0;
      gyro_zero  = 1'b0;
      gyro_fin   = 1'b0;
      accel_act  = 1'b0;
      accel_zero = 1'b0;
      accel_fin  = 1'b0;

      if (phase == ibc_pkg::PH_IDLE) begin
         priority if (pend[0]) begin
            phase = ibc_pkg::PH_GYRO;
         end else if (pend[1]) begin
            phase = ibc_pkg::PH_ACCEL;
         end else begin
            phase = ibc_pkg::PH_IDLE;
         end
      end

      if (phase == ibc_pkg::PH_GYRO_INIT || phase == ibc_pkg::PH_GYRO) begin
         gyro_act  = 1'b1;
         pend[0]   = 1'b0;
         gyro_zero = (cnt == '0);
         if (gyro_zero) begin
            cnt = CNT_W'(1);
         end
         gyro_fin = (cnt >= SAMPLES_CNT);
         if (gyro_fin) begin
            cnt = '0;
            if (phase == ibc_pkg::PH_GYRO_INIT || pend[1]) begin
               phase = ibc_pkg::PH_ACCEL;
            end else begin
               phase = ibc_pkg::PH_IDLE;
            end
         end else begin
            cnt = cnt + 1'b1;
         end
      end

      if (phase == ibc_pkg::PH_ACCEL) begin
         accel_act  = 1'b1;
         pend[1]    = 1'b0;
         accel_zero = (cnt == '0);
         if (accel_zero) begin
            cnt = CNT_W'(1);
         end
         accel_fin = (cnt >= SAMPLES_CNT);
         if (accel_fin) begin
            cnt   = '0;
            phase = ibc_pkg::PH_IDLE;
         end else begin
            cnt = cnt + 1'b1;
         end
      end

      phase_in   = accept ? phase : phase_ff;
      count_in   = accept ? cnt : count_ff;
      pending_in = accept ? pend : pending_ff;

      lane_ctrl.load_init  = accept && (gyro_zero || accel_zero);
      lane_ctrl.accumulate = accept && ((gyro_act && !gyro_zero) || (accel_act && !accel_zero));
      lane_ctrl.capture    = accept && (gyro_fin || accel_fin);

      div_in      = div_ff;
      div_gyro_in = lane_ctrl.capture ? gyro_fin : div_gyro_ff;
      offset_ctrl.clr_gyro  = accept && gyro_zero;
      offset_ctrl.clr_accel = accept && accel_zero;
      offset_ctrl.wr_gyro   = 1'b0;
      offset_ctrl.wr_accel  = 1'b0;
      unique case (div_ff)
         ibc_pkg::DIV_IDLE: begin
            if (lane_ctrl.capture) begin
               div_in = ibc_pkg::DIV_ABS;
            end
         end
         ibc_pkg::DIV_ABS: begin
            div_in = ibc_pkg::DIV_MUL;
         end
         ibc_pkg::DIV_MUL: begin
            div_in = ibc_pkg::DIV_WRITE;
         end
         ibc_pkg::DIV_WRITE: begin
            div_in = ibc_pkg::DIV_IDLE;
            offset_ctrl.wr_gyro  = div_gyro_ff;
            offset_ctrl.wr_accel = !div_gyro_ff;
         end
         default: begin
            div_in = ibc_pkg::DIV_IDLE;
         end
      endcase

      status.use_gyro   = gyro_act && !gyro_zero;
      status.accel_zero = accel_zero;
      status.gyro_done  = gyro_fin;
      status.accel_done = accel_fin;
      status.busy       = (div_ff != ibc_pkg::DIV_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ibc_pkg::PH_GYRO_INIT;
         count_ff    <= '0;
         pending_ff  <= '0;
         div_ff      <= ibc_pkg::DIV_IDLE;
         div_gyro_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         pending_ff  <= pending_in;
         div_ff      <= div_in;
         div_gyro_ff <= div_gyro_in;
      end
   end

endmodule

FILE: rtl/core/imu_bias_calibration_unit.sv
// Top level of the IMU bias calibration unit: lanes, offset store and output register.
//
//   Channel  Direction  Handshake               Payload
//   req_     in         req_tvalid/req_tready   tdata six raw axes, tuser two requests
//   rsp_     out        rsp_tvalid/rsp_tready   tdata six corrected axes, tuser two dones
//   csr_     in         csr_valid/csr_ready     csr_data gravity in accel counts
//
// A frame's result is registered as the frame is taken. A frame that completes a
// calibration stops intake while the divider is busy and each axis lane turns its
// sum into an offset through one reciprocal multiplier. Sustained rate is one frame
// per cycle while the divider is idle and the output is not stalled. Reset is
// synchronous; there is no clearing pass. The csr port is always ready.
`timescale 1ns / 1ps

module imu_bias_calibration_unit #(
   parameter int SAMPLES = 200
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
   input  logic [95:0]  req_tdata,
   // gyro_cal_request, accel_cal_request
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out, gyro_z_out
   output logic [95:0]  rsp_tdata,
   // gyro_cal_done, accel_cal_done
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   localparam int AXIS_W    = ibc_pkg::AXIS_W;
   localparam int VAL_W     = ibc_pkg::VAL_W;
   localparam int NUM_LANES = ibc_pkg::NUM_LANES;
   localparam int FRAME_W   = ibc_pkg::FRAME_W;

   ibc_pkg::ibc_lane_ctrl_type   lane_ctrl;
   ibc_pkg::ibc_offset_ctrl_type offset_ctrl;
   ibc_pkg::ibc_cal_status_type  status;

   logic                accept;
   logic [AXIS_W-1:0]   gravity_ff, gravity_in;
   logic [AXIS_W-1:0]   gyro_off_ff  [NUM_LANES];
   logic [AXIS_W-1:0]   accel_off_ff [NUM_LANES];
   logic [AXIS_W-1:0]   quotient     [NUM_LANES];
   logic [FRAME_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]    grav_ext;

   assign grav_ext   = {{(VAL_W-AXIS_W){1'b0}}, gravity_ff};
   assign req_tready = !status.busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign gravity_in = (csr_valid && csr_ready) ? csr_data : gravity_ff;

   ibc_cal_ctrl #(
      .SAMPLES(SAMPLES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .gyro_req   (req_tuser[0]),
      .accel_req  (req_tuser[1]),
      .lane_ctrl  (lane_ctrl),
      .offset_ctrl(offset_ctrl),
      .status     (status)
   );

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      logic [AXIS_W-1:0] accel_raw, gyro_raw;
      logic [VAL_W-1:0]  accel_ext, gyro_ext, grav_term, add_val, init_val;

      assign accel_raw = req_tdata[AXIS_W*i +: AXIS_W];
      assign gyro_raw  = req_tdata[AXIS_W*(NUM_LANES+i) +: AXIS_W];
      assign accel_ext = {{(VAL_W-AXIS_W){accel_raw[AXIS_W-1]}}, accel_raw};
      assign gyro_ext  = {{(VAL_W-AXIS_W){gyro_raw[AXIS_W-1]}}, gyro_raw};
      assign grav_term = (i == NUM_LANES - 1) ? grav_ext : '0;
      assign add_val   = status.use_gyro ? gyro_ext : (accel_ext - grav_term);
      assign init_val  = status.accel_zero ? (~grav_term + 1'b1) : '0;

      ibc_axis_lane #(
         .SAMPLES(SAMPLES)
      ) u_lane (
         .clock    (clock),
         .lane_ctrl(lane_ctrl),
         .add_val  (add_val),
         .init_val (init_val),
         .quotient (quotient[i])
      );

      assign rsp_data_in[AXIS_W*i +: AXIS_W] = accel_raw - accel_off_ff[i];
      assign rsp_data_in[AXIS_W*(NUM_LANES+i) +: AXIS_W] = gyro_raw - gyro_off_ff[i];
   end

   assign rsp_user_in  = {status.accel_done, status.gyro_done};
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= ibc_pkg::GRAVITY_RESET;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < NUM_LANES; j++) begin
            gyro_off_ff[j]  <= '0;
            accel_off_ff[j] <= '0;
         end
      end else begin
         gravity_ff   <= gravity_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int j = 0; j < NUM_LANES; j++) begin
            if (offset_ctrl.clr_gyro) begin
               gyro_off_ff[j] <= '0;
            end else if (offset_ctrl.wr_gyro) begin
               gyro_off_ff[j] <= quotient[j];
            end
            if (offset_ctrl.clr_accel) begin
               accel_off_ff[j] <= '0;
            end else if (offset_ctrl.wr_accel) begin
               accel_off_ff[j] <= quotient[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_offset_write_follows : assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.capture |=> ##2 (offset_ctrl.wr_gyro || offset_ctrl.wr_accel))
      else $error("Offset write did not follow a completed calibration.");

   a_single_done : assert property (@(posedge clock) disable iff (reset)
      accept |-> !(status.gyro_done && status.accel_done))
      else $error("Both calibrations completed on one frame.");

   a_no_clear_during_write : assert property (@(posedge clock) disable iff (reset)
      (offset_ctrl.wr_gyro || offset_ctrl.wr_accel) |->
         !(offset_ctrl.clr_gyro || offset_ctrl.clr_accel || accept))
      else $error("Frame transfer overlapped an offset write.");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the IMU bias calibration unit.
`timescale 1ns / 1ps

module tb;

   localparam int AXIS_W         = ibc_pkg::AXIS_W;
   localparam int SUM_W          = ibc_pkg::SUM_W;
   localparam int CNT_W          = ibc_pkg::CNT_W;
   localparam int NUM_LANES      = ibc_pkg::NUM_LANES;
   localparam int CENTER_W       = NUM_LANES * AXIS_W;
   localparam int SAMPLES        = 200;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int SEGMENTS       = 3;
   localparam int SEGMENT_FRAMES = 16;
   localparam int HOLD_AFTER     = 600;
   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int REQ_GYRO       = 0;
   localparam int REQ_ACCEL      = 1;

   localparam logic [AXIS_W-1:0] GRAVITY_SETTINGS [SEGMENTS] =
      '{16'hFFFF, 16'h0000, 16'h0001};

   typedef enum int {
      STYLE_FULL,
      STYLE_BIASED,
      STYLE_EXTREME
   } data_style_type;

   typedef enum int {
      PACE_OPEN,
      PACE_COIN,
      PACE_SPARSE,
      PACE_PATTERN
   } pace_mode_type;

   typedef struct packed {
      logic                                accel_req;
      logic                                gyro_req;
      logic [NUM_LANES-1:0][AXIS_W-1:0]    gyr;
      logic [NUM_LANES-1:0][AXIS_W-1:0]    acc;
   } imu_frame_type;

   typedef struct packed {
      logic                                accel_done;
      logic                                gyro_done;
      logic [NUM_LANES-1:0][AXIS_W-1:0]    gyr;
      logic [NUM_LANES-1:0][AXIS_W-1:0]    acc;
   } corrected_frame_type;

   typedef struct packed {
      logic [AXIS_W-1:0] ax, ay, az, gx, gy, gz;
      logic              gyro_req, accel_req, typed;
      logic [AXIS_W-1:0] ex_ax, ex_ay, ex_az, ex_gx, ex_gy, ex_gz;
      logic              ex_gdone, ex_adone;
   } directed_row_type;

   // During the first gyro calibration after reset every offset is zero,
   // so each corrected axis equals its raw word and no done flag is raised.
   localparam directed_row_type DIRECTED_ROWS [14] = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b1,
        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b1,
        16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0},
      '{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b0, 1'b1,
        16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b0},
      '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b1,
        16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 1'b1,
        16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b1,
        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0},
      '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b1,
        16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0},
      '{16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 1'b1, 1'b0, 1'b1,
        16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 1'b0, 1'b0},
      '{16'h4000, 16'hC000, 16'h2004, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1,
        16'h4000, 16'hC000, 16'h2004, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0064, 16'hFF9C, 16'h0032, 1'b1, 1'b1, 1'b1,
        16'h0000, 16'h0000, 16'h0000, 16'h0064, 16'hFF9C, 16'h0032, 1'b0, 1'b0},
      '{16'h8001, 16'h7FFE, 16'h0000, 16'hFFFE, 16'h0002, 16'h8000, 1'b0, 1'b0, 1'b1,
        16'h8001, 16'h7FFE, 16'h0000, 16'hFFFE, 16'h0002, 16'h8000, 1'b0, 1'b0},
      '{16'h2004, 16'h2004, 16'h2004, 16'h2004, 16'h2004, 16'h2004, 1'b0, 1'b0, 1'b0,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;

   ibc_pkg::ibc_phase_type              cal_phase_q;
   logic [CNT_W-1:0]                    frame_count;
   logic signed [SUM_W-1:0]             lane_sum [NUM_LANES];
   logic [NUM_LANES-1:0][AXIS_W-1:0]    gyro_bias;
   logic [NUM_LANES-1:0][AXIS_W-1:0]    accel_bias;
   logic [1:0]                          open_requests;
   logic [AXIS_W-1:0]                   gravity_counts;

   corrected_frame_type                 corrected_q [$];
   data_style_type                      data_style;
   logic [NUM_LANES-1:0][AXIS_W-1:0]    acc_center;
   logic [NUM_LANES-1:0][AXIS_W-1:0]    gyr_center;
   int                                  frames_accepted = 0;
   int                                  burst_left = 1;
   bit                                  offering = 1'b0;
   int                                  fault_count = 0;
   int                                  cycle_count = 0;

   imu_bias_calibration_unit #(
      .SAMPLES(SAMPLES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic accumulate_lanes(input logic [NUM_LANES-1:0][AXIS_W-1:0] raw,
                                             input logic [AXIS_W-1:0] grav,
                                             inout logic [NUM_LANES-1:0][AXIS_W-1:0] bias);
      logic signed [SUM_W-1:0] term [NUM_LANES];
      int                      quotient;
      logic                    done;
      done = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         term[i] = (frame_count == 0) ? '0 : {{(SUM_W-AXIS_W){raw[i][AXIS_W-1]}}, raw[i]};
      end
      if (frame_count == 0) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            lane_sum[i] = '0;
         end
         bias = '0;
         frame_count = CNT_W'(1);
      end
      lane_sum[0] = lane_sum[0] + term[0];
      lane_sum[1] = lane_sum[1] + term[1];
      lane_sum[2] = lane_sum[2] + term[2] - $signed({{(SUM_W-AXIS_W){1'b0}}, grav});
      if (frame_count >= SAMPLES) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            quotient = int'(lane_sum[i]) / SAMPLES;
            bias[i] = quotient[AXIS_W-1:0];
         end
         frame_count = '0;
         done = 1'b1;
      end else begin
         frame_count = frame_count + 1'b1;
      end
      return done;
   endfunction

   function automatic corrected_frame_type predict_correction(input imu_frame_type f);
      corrected_frame_type r;
      r = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         r.acc[i] = f.acc[i] - accel_bias[i];
         r.gyr[i] = f.gyr[i] - gyro_bias[i];
      end
      open_requests = open_requests | {f.accel_req, f.gyro_req};
      if (cal_phase_q == ibc_pkg::PH_IDLE) begin
         if (open_requests[REQ_GYRO]) begin
            cal_phase_q = ibc_pkg::PH_GYRO;
         end else if (open_requests[REQ_ACCEL]) begin
            cal_phase_q = ibc_pkg::PH_ACCEL;
         end
      end
      if (cal_phase_q == ibc_pkg::PH_GYRO_INIT || cal_phase_q == ibc_pkg::PH_GYRO) begin
         open_requests[REQ_GYRO] = 1'b0;
         if (accumulate_lanes(f.gyr, '0, gyro_bias)) begin
            r.gyro_done = 1'b1;
            if (cal_phase_q == ibc_pkg::PH_GYRO_INIT || open_requests[REQ_ACCEL]) begin
               cal_phase_q = ibc_pkg::PH_ACCEL;
            end else begin
               cal_phase_q = ibc_pkg::PH_IDLE;
            end
         end
      end
      if (cal_phase_q == ibc_pkg::PH_ACCEL) begin
         open_requests[REQ_ACCEL] = 1'b0;
         if (accumulate_lanes(f.acc, gravity_counts, accel_bias)) begin
            r.accel_done = 1'b1;
            cal_phase_q = ibc_pkg::PH_IDLE;
         end
      end
      return r;
   endfunction

   function automatic void pick_style();
      data_style = data_style_type'($urandom_range(STYLE_FULL, STYLE_EXTREME));
      acc_center = CENTER_W'({$urandom, $urandom});
      gyr_center = CENTER_W'({$urandom, $urandom});
   endfunction

   function automatic logic [AXIS_W-1:0] draw_axis(input logic [AXIS_W-1:0] center);
      case (data_style)
         STYLE_FULL: begin
            return AXIS_W'($urandom);
         end
         STYLE_BIASED: begin
            return center + AXIS_W'($urandom_range(0, 511)) - 16'd256;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'hFFFF;
               3: return 16'h0000;
               default: return 16'h0001;
            endcase
         end
      endcase
   endfunction

   // Requests come often while the unit rests and rarely during a calibration,
   // so phases chain, get absorbed requests and get held requests for the other sensor.
   function automatic imu_frame_type draw_frame(input bit allow_requests);
      imu_frame_type f;
      int            pick;
      f = '0;
      if (allow_requests) begin
         if (cal_phase_q == ibc_pkg::PH_IDLE && open_requests == 0) begin
            if ($urandom_range(0, 3) == 0) begin
               pick = $urandom_range(0, 9);
               f.gyro_req = (pick < 5);
               f.accel_req = (pick < 2) || (pick >= 5);
               pick_style();
            end
         end else begin
            f.gyro_req = ($urandom_range(0, 99) == 0);
            f.accel_req = ($urandom_range(0, 99) == 0);
         end
      end
      for (int i = 0; i < NUM_LANES; i++) begin
         f.acc[i] = draw_axis(acc_center[i]);
         f.gyr[i] = draw_axis(gyr_center[i]);
      end
      return f;
   endfunction

   task automatic send_frame(input imu_frame_type f, input bit typed,
                             input corrected_frame_type typed_result);
      corrected_frame_type predicted;
      req_tvalid <= 1'b1;
      req_tdata <= {f.gyr, f.acc};
      req_tuser <= {f.accel_req, f.gyro_req};
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = predict_correction(f);
      corrected_q.push_back(typed ? typed_result : predicted);
      frames_accepted++;
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 60);
      end
   endtask

   task automatic bring_to_rest();
      while (cal_phase_q != ibc_pkg::PH_IDLE || open_requests != 0) begin
         send_frame(draw_frame(1'b0), 1'b0, '0);
      end
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (corrected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gravity(input logic [AXIS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      gravity_counts = value;
   endtask

   function automatic void compare_field(input string name, input logic [AXIS_W-1:0] want,
                                         input logic [AXIS_W-1:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT) begin
            $display("Mismatch on %s: expected %h, got %h", name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      corrected_frame_type got;
      corrected_frame_type want;
      string               axis_name [NUM_LANES];
      axis_name = '{"x", "y", "z"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         if (corrected_q.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("Unexpected result transfer: %h", got);
            end
         end else begin
            want = corrected_q.pop_front();
            for (int i = 0; i < NUM_LANES; i++) begin
               compare_field({"accel_", axis_name[i], "_out"}, want.acc[i], got.acc[i]);
               compare_field({"gyro_", axis_name[i], "_out"}, want.gyr[i], got.gyr[i]);
            end
            compare_field("gyro_cal_done", AXIS_W'(want.gyro_done), AXIS_W'(got.gyro_done));
            compare_field("accel_cal_done", AXIS_W'(want.accel_done), AXIS_W'(got.accel_done));
         end
      end
   end

   initial begin : rsp_pacing
      pace_mode_type mode;
      int            span;
      bit            hold_done;
      logic [7:0]    pattern;
      hold_done = 1'b0;
      pattern = 8'b1011_0110;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && frames_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = pace_mode_type'($urandom_range(PACE_OPEN, PACE_PATTERN));
         span = $urandom_range(16, 96);
         for (int k = 0; k < span; k++) begin
            case (mode)
               PACE_OPEN:   rsp_tready <= 1'b1;
               PACE_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               PACE_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= pattern[k % 8];
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type    row;
      imu_frame_type       f;
      corrected_frame_type t;
      cal_phase_q = ibc_pkg::PH_GYRO_INIT;
      frame_count = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_sum[i] = '0;
      end
      gyro_bias = '0;
      accel_bias = '0;
      open_requests = '0;
      gravity_counts = ibc_pkg::GRAVITY_RESET;
      pick_style();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 60);

      for (int n = 0; n < $size(DIRECTED_ROWS); n++) begin
         row = DIRECTED_ROWS[n];
         f = '0;
         f.acc = {row.az, row.ay, row.ax};
         f.gyr = {row.gz, row.gy, row.gx};
         f.gyro_req = row.gyro_req;
         f.accel_req = row.accel_req;
         t = '0;
         t.acc = {row.ex_az, row.ex_ay, row.ex_ax};
         t.gyr = {row.ex_gz, row.ex_gy, row.ex_gx};
         t.gyro_done = row.ex_gdone;
         t.accel_done = row.ex_adone;
         send_frame(f, row.typed, t);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         bring_to_rest();
         write_gravity(GRAVITY_SETTINGS[seg]);
         pick_style();
         for (int k = 0; k < SEGMENT_FRAMES; k++) begin
            send_frame(draw_frame(1'b1), 1'b0, '0);
         end
      end
      bring_to_rest();

      if (fault_count == 0 && corrected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
